// ----- src/xhp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xhp_pkg
// Shared types, codes and helpers of the header record parser.
// ----------------------------------------------------------------------------
package xhp_pkg;

  localparam int ANNOTATION_CHARS = 61;
  localparam int PROJECTION_CHARS = 32;

  localparam logic [13:0] MAX_HEADER_LENGTH_RESET = 14'd10000;
  localparam logic [31:0] MIN_HEADER_LENGTH = 32'd10;
  localparam logic [31:0] PRIMARY_LENGTH = 32'd16;
  localparam int RES_SLOTS = 3;
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic REG_SEGMENT_LAYOUT = 1'b0;
  localparam logic REG_MAX_HEADER_LENGTH = 1'b1;

  // field codes
  localparam logic [4:0] F_FILE_TYPE = 5'd0;
  localparam logic [4:0] F_HEADER_LENGTH = 5'd1;
  localparam logic [4:0] F_DATA_LENGTH = 5'd2;
  localparam logic [4:0] F_BITPLANES = 5'd3;
  localparam logic [4:0] F_COLUMNS = 5'd4;
  localparam logic [4:0] F_LINES = 5'd5;
  localparam logic [4:0] F_COMPRESSION = 5'd6;
  localparam logic [4:0] F_PROJECTION_CHAR = 5'd7;
  localparam logic [4:0] F_COLUMN_FACTOR = 5'd8;
  localparam logic [4:0] F_LINE_FACTOR = 5'd9;
  localparam logic [4:0] F_COLUMN_OFFSET = 5'd10;
  localparam logic [4:0] F_LINE_OFFSET = 5'd11;
  localparam logic [4:0] F_SCAN_DIRECTION = 5'd12;
  localparam logic [4:0] F_ANNOTATION_CHAR = 5'd13;
  localparam logic [4:0] F_TIMESTAMP = 5'd14;
  localparam logic [4:0] F_GROUP_ID = 5'd15;
  localparam logic [4:0] F_SPECTRAL_CHANNEL = 5'd16;
  localparam logic [4:0] F_SEGMENT_NUMBER = 5'd17;
  localparam logic [4:0] F_PLANNED_START = 5'd18;
  localparam logic [4:0] F_PLANNED_END = 5'd19;
  localparam logic [4:0] F_REPEAT_FLAG = 5'd20;
  localparam logic [4:0] F_UNKNOWN_RECORD = 5'd21;
  localparam logic [4:0] F_HEADER_END = 5'd22;
  localparam logic [4:0] F_IMAGE_FORMAT = 5'd23;
  localparam logic [4:0] F_ERROR = 5'd24;

  // error values
  localparam logic [56:0] ERR_BAD_PRIMARY = 57'd0;
  localparam logic [56:0] ERR_OVERRUN = 57'd1;
  localparam logic [56:0] ERR_SHORT_RECORD = 57'd2;

  // image format values
  localparam logic [56:0] FMT_WAVELET = 57'd0;
  localparam logic [56:0] FMT_JPEG = 57'd1;
  localparam logic [56:0] FMT_OTHER = 57'd2;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_WAVELET = 8'h01;
  localparam logic [7:0] MARK_JPEG = 8'hD8;

  // record types
  localparam logic [7:0] REC_PRIMARY = 8'd0;
  localparam logic [7:0] REC_IMAGE_STRUCT = 8'd1;
  localparam logic [7:0] REC_NAVIGATION = 8'd2;
  localparam logic [7:0] REC_ANNOTATION = 8'd4;
  localparam logic [7:0] REC_TIMESTAMP = 8'd5;
  localparam logic [7:0] REC_SEGMENT = 8'd128;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRIMARY = 2'd1,
    PH_RECORDS = 2'd2,
    PH_FORMAT  = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [13:0] pos;
    logic [7:0]  rtype;
    logic [13:0] rlen;
    logic [13:0] total;
    logic [13:0] consumed;
    logic [55:0] acc;
    logic [31:0] hi_word;
    logic [7:0]  ftype;
    logic [7:0]  fmt_byte;
  } state_t;

  typedef struct packed {
    logic        layout;
    logic [13:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  code;
    logic [56:0] value;
    logic        fin;
  } res_t;

  function automatic res_t mk_res(logic [4:0] code, logic [56:0] value, logic fin);
    res_t r;
    r.code = code;
    r.value = value;
    r.fin = fin;
    return r;
  endfunction

  function automatic logic [56:0] sext32(logic [31:0] v);
    return {{25{v[31]}}, v};
  endfunction

  function automatic logic known_type(logic [7:0] t);
    return ((t >= 8'd1) && (t <= 8'd7)) || ((t >= 8'd128) && (t <= 8'd131));
  endfunction

endpackage
`default_nettype wire

// ----- src/xhp_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xhp_in_if
// Header byte channel: valid/ready with one stream byte per word.
// ----------------------------------------------------------------------------
interface xhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface
`default_nettype wire

// ----- src/xhp_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xhp_out_if
// Decoded field channel: valid/ready with one code/value pair per word.
// ----------------------------------------------------------------------------
interface xhp_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         field_code;
  logic signed [56:0] field_value;
  logic               final_res;

  modport source (output valid, output field_code, output field_value, output final_res,
                  input ready);
  modport sink (input valid, input field_code, input field_value, input final_res,
                output ready);
endinterface
`default_nettype wire

// ----- src/xhp_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xhp_decode
// Per-byte record walk: next parser state and up to three decoded fields.
// ----------------------------------------------------------------------------
module xhp_decode #(
  parameter int ANNOTATION_CHARS = xhp_pkg::ANNOTATION_CHARS,
  parameter int PROJECTION_CHARS = xhp_pkg::PROJECTION_CHARS
) (
  input  var xhp_pkg::state_t st,
  input  var xhp_pkg::cfg_t   cfg,
  input  wire logic [7:0]     data_byte,
  input  wire logic           start_of_file,
  output xhp_pkg::state_t     st_next,
  output xhp_pkg::res_t       res [xhp_pkg::RES_SLOTS],
  output logic [1:0]          res_count
);

  localparam logic [13:0] PROJ_END = 14'(3 + PROJECTION_CHARS);
  localparam logic [13:0] ANNOT_END = 14'(3 + ANNOTATION_CHARS);

  xhp_pkg::state_t cur;
  xhp_pkg::state_t nx;
  xhp_pkg::res_t   ev [xhp_pkg::RES_SLOTS];
  logic [2:0]      ev_ok;
  logic [55:0]     acc;
  logic [7:0]      b;
  logic [13:0]     p;
  logic [31:0]     t;
  logic [15:0]     len;
  logic [16:0]     lsum;
  logic [55:0]     dlen;
  logic [14:0]     pnext;
  logic [13:0]     csum;
  logic [56:0]     fmt;
  logic            fin_hdr;
  logic            failed;
  logic            image;
  logic [1:0]      n;

  always_comb begin
    b = data_byte;
    cur = st;
    if (start_of_file) begin
      cur = '0;
      cur.phase = xhp_pkg::PH_PRIMARY;
    end
    acc = {cur.acc[47:0], b};
    p = cur.pos;
    pnext = {1'b0, p} + 15'd1;
    t = acc[31:0];
    len = acc[15:0];
    lsum = {3'b0, cur.consumed} + {1'b0, len};
    dlen = (cur.hi_word[31:27] != 5'd0) ? '1 : {cur.hi_word[26:0], acc[31:3]};
    fmt = xhp_pkg::FMT_OTHER;
    if ((cur.fmt_byte == xhp_pkg::MARK_PREFIX) && (b == xhp_pkg::MARK_WAVELET)) begin
      fmt = xhp_pkg::FMT_WAVELET;
    end else if ((cur.fmt_byte == xhp_pkg::MARK_PREFIX) && (b == xhp_pkg::MARK_JPEG)) begin
      fmt = xhp_pkg::FMT_JPEG;
    end
    for (int k = 0; k < xhp_pkg::RES_SLOTS; k++) begin
      ev[k] = '0;
    end
    ev_ok = 3'b000;
    fin_hdr = 1'b0;
    failed = 1'b0;
    csum = '0;
    nx = cur;
    nx.acc = acc;

    unique case (cur.phase)
      xhp_pkg::PH_PRIMARY: begin
        nx.pos = pnext[13:0];
        if (p == 14'd0) begin
          nx.rtype = b;
        end else if (p == 14'd2) begin
          nx.rlen = 14'd16;
          if ((cur.rtype != xhp_pkg::REC_PRIMARY) ||
              ({16'b0, len} != xhp_pkg::PRIMARY_LENGTH)) begin
            failed = 1'b1;
            ev[0] = xhp_pkg::mk_res(xhp_pkg::F_ERROR, xhp_pkg::ERR_BAD_PRIMARY, 1'b1);
          end
        end else if (p == 14'd3) begin
          nx.ftype = b;
          ev[0] = xhp_pkg::mk_res(xhp_pkg::F_FILE_TYPE, 57'(b), 1'b0);
        end else if (p == 14'd7) begin
          if ((t < xhp_pkg::MIN_HEADER_LENGTH) || (t > {18'b0, cfg.max_len})) begin
            failed = 1'b1;
            ev[0] = xhp_pkg::mk_res(xhp_pkg::F_ERROR, xhp_pkg::ERR_BAD_PRIMARY, 1'b1);
          end else if (t < xhp_pkg::PRIMARY_LENGTH) begin
            failed = 1'b1;
            ev[0] = xhp_pkg::mk_res(xhp_pkg::F_ERROR, xhp_pkg::ERR_OVERRUN, 1'b1);
          end else begin
            nx.total = t[13:0];
            ev[0] = xhp_pkg::mk_res(xhp_pkg::F_HEADER_LENGTH, 57'(t), 1'b0);
          end
        end else if (p == 14'd11) begin
          nx.hi_word = t;
        end else if (p == 14'd15) begin
          ev[0] = xhp_pkg::mk_res(xhp_pkg::F_DATA_LENGTH, 57'(dlen), 1'b0);
          nx.consumed = 14'd16;
          nx.pos = '0;
          if (cur.total <= 14'd16) begin
            fin_hdr = 1'b1;
          end else begin
            nx.phase = xhp_pkg::PH_RECORDS;
          end
        end
        if (failed) begin
          nx.pos = p;
          nx.phase = xhp_pkg::PH_IDLE;
        end
      end
      xhp_pkg::PH_RECORDS: begin
        if (p == 14'd0) begin
          nx.rtype = b;
          if (!xhp_pkg::known_type(b)) begin
            ev[0] = xhp_pkg::mk_res(xhp_pkg::F_UNKNOWN_RECORD, 57'(b), 1'b0);
          end
        end else if (p == 14'd2) begin
          if (len < 16'd3) begin
            failed = 1'b1;
            ev[0] = xhp_pkg::mk_res(xhp_pkg::F_ERROR, xhp_pkg::ERR_SHORT_RECORD, 1'b1);
          end else if (lsum > {3'b0, cur.total}) begin
            failed = 1'b1;
            ev[0] = xhp_pkg::mk_res(xhp_pkg::F_ERROR, xhp_pkg::ERR_OVERRUN, 1'b1);
          end else begin
            nx.rlen = len[13:0];
          end
        end else if (p >= 14'd3) begin
          unique case (cur.rtype)
            xhp_pkg::REC_IMAGE_STRUCT: begin
              if (p == 14'd3) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_BITPLANES, 57'(b), 1'b0);
              end else if (p == 14'd5) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_COLUMNS, 57'(acc[15:0]), 1'b0);
              end else if (p == 14'd7) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_LINES, 57'(acc[15:0]), 1'b0);
              end else if (p == 14'd8) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_COMPRESSION, 57'(b), 1'b0);
              end
            end
            xhp_pkg::REC_NAVIGATION: begin
              if (p < PROJ_END) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_PROJECTION_CHAR, 57'(b), 1'b0);
              end else if (p == 14'd38) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_COLUMN_FACTOR, xhp_pkg::sext32(t), 1'b0);
              end else if (p == 14'd42) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_LINE_FACTOR, xhp_pkg::sext32(t), 1'b0);
                if (t != 32'd0) begin
                  ev[1] = xhp_pkg::mk_res(xhp_pkg::F_SCAN_DIRECTION, 57'(t[31]), 1'b0);
                end
              end else if (p == 14'd46) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_COLUMN_OFFSET, xhp_pkg::sext32(t), 1'b0);
              end else if (p == 14'd50) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_LINE_OFFSET, xhp_pkg::sext32(t), 1'b0);
              end
            end
            xhp_pkg::REC_ANNOTATION: begin
              if (p < ANNOT_END) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_ANNOTATION_CHAR, 57'(b), 1'b0);
              end
            end
            xhp_pkg::REC_TIMESTAMP: begin
              if (p == 14'd9) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_TIMESTAMP, 57'(acc), 1'b0);
              end
            end
            xhp_pkg::REC_SEGMENT: begin
              if (p == 14'd4) begin
                ev[0] = xhp_pkg::mk_res(xhp_pkg::F_GROUP_ID, 57'(acc[15:0]), 1'b0);
              end else if (!cfg.layout) begin
                if (p == 14'd5) begin
                  ev[0] = xhp_pkg::mk_res(xhp_pkg::F_SPECTRAL_CHANNEL, 57'(b), 1'b0);
                end else if (p == 14'd7) begin
                  ev[0] = xhp_pkg::mk_res(xhp_pkg::F_SEGMENT_NUMBER, 57'(acc[15:0]), 1'b0);
                end else if (p == 14'd9) begin
                  ev[0] = xhp_pkg::mk_res(xhp_pkg::F_PLANNED_START, 57'(acc[15:0]), 1'b0);
                end else if (p == 14'd11) begin
                  ev[0] = xhp_pkg::mk_res(xhp_pkg::F_PLANNED_END, 57'(acc[15:0]), 1'b0);
                end else if (p == 14'd12) begin
                  ev[0] = xhp_pkg::mk_res(xhp_pkg::F_REPEAT_FLAG, 57'(b), 1'b0);
                end
              end else begin
                if (p == 14'd6) begin
                  ev[0] = xhp_pkg::mk_res(xhp_pkg::F_SEGMENT_NUMBER, 57'(acc[15:0]), 1'b0);
                  ev[1] = xhp_pkg::mk_res(xhp_pkg::F_PLANNED_START, 57'd1, 1'b0);
                end else if (p == 14'd12) begin
                  ev[0] = xhp_pkg::mk_res(xhp_pkg::F_PLANNED_END, 57'(acc[15:0]), 1'b0);
                end
              end
            end
            default: begin
            end
          endcase
        end
        if (failed) begin
          nx.phase = xhp_pkg::PH_IDLE;
        end else if ((p >= 14'd2) && (pnext >= {1'b0, nx.rlen})) begin
          csum = cur.consumed + nx.rlen;
          nx.consumed = csum;
          nx.pos = '0;
          fin_hdr = (csum >= cur.total);
        end else begin
          nx.pos = pnext[13:0];
        end
      end
      xhp_pkg::PH_FORMAT: begin
        if (p == 14'd0) begin
          nx.fmt_byte = b;
          nx.pos = 14'd1;
        end else begin
          ev[0] = xhp_pkg::mk_res(xhp_pkg::F_IMAGE_FORMAT, fmt, 1'b1);
          nx.phase = xhp_pkg::PH_IDLE;
          nx.pos = '0;
        end
      end
      default: begin
        nx = st;
      end
    endcase

    image = (cur.ftype == 8'd0);
    if (fin_hdr) begin
      ev[2] = xhp_pkg::mk_res(xhp_pkg::F_HEADER_END, 57'(cur.total), !image);
      nx.pos = '0;
      nx.phase = image ? xhp_pkg::PH_FORMAT : xhp_pkg::PH_IDLE;
    end

    ev_ok[0] = (cur.phase != xhp_pkg::PH_IDLE) &&
               ((cur.phase == xhp_pkg::PH_FORMAT) ? (p != 14'd0) : (ev[0].code != '0 ||
                ev[0].value != '0 || ev[0].fin || ((cur.phase == xhp_pkg::PH_PRIMARY) &&
                (p == 14'd3))));
    ev_ok[1] = (ev[1].code != '0);
    ev_ok[2] = fin_hdr;

    // pack the valid events in order
    for (int k = 0; k < xhp_pkg::RES_SLOTS; k++) begin
      res[k] = '0;
    end
    n = 2'd0;
    for (int k = 0; k < xhp_pkg::RES_SLOTS; k++) begin
      if (ev_ok[k]) begin
        res[n] = ev[k];
        n = n + 2'd1;
      end
    end
    res_count = n;
    st_next = nx;
  end

endmodule
`default_nettype wire

// ----- src/xrit_header_record_parser_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xrit_header_record_parser_unit
// Walks file header records one byte per word and emits decoded fields.
//
// in_chan carries one header byte per word; start_of_file marks byte 0 of a
// file and restarts the parse. out_chan carries code/value pairs; final_res
// is set on the last pair for a header (error, header end of a non-image
// file, or the image format).
// Each byte is decoded in the cycle it is accepted and its fields are
// registered into the result queue that feeds out_chan. One byte is accepted
// every cycle while each byte yields at most one field and out_chan is not
// stalled; a byte that yields two or three fields is drained one field at a
// time by the single output port from a four-word result queue. in_chan.ready
// is high while at most one word waits in that queue, so it does not depend
// on out_chan.ready in the same cycle. When the receiver stalls, bytes that
// yield no field keep flowing; input stops once two words wait, and the
// queue then holds at most four.
// Reset empties the queue, sets the parser idle awaiting a start-of-file
// byte, and loads segment_layout with 0 and max_header_length with 10000.
// The cfg port writes segment_layout (index 0) or max_header_length (index 1).
// ----------------------------------------------------------------------------
module xrit_header_record_parser_unit #(
  parameter int ANNOTATION_CHARS = xhp_pkg::ANNOTATION_CHARS,
  parameter int PROJECTION_CHARS = xhp_pkg::PROJECTION_CHARS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  xhp_in_if.sink            in_chan,
  xhp_out_if.source         out_chan,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [13:0]  cfg_data
);

  localparam int PW = $clog2(xhp_pkg::QUEUE_DEPTH);

  xhp_pkg::state_t st;
  xhp_pkg::state_t st_next;
  xhp_pkg::cfg_t   cfg;
  xhp_pkg::res_t   res [xhp_pkg::RES_SLOTS];
  logic [1:0]      res_count;
  xhp_pkg::res_t   queue [xhp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     cnt;
  logic            push;
  logic            pop;

  xhp_decode #(
    .ANNOTATION_CHARS (ANNOTATION_CHARS),
    .PROJECTION_CHARS (PROJECTION_CHARS)
  ) u_decode (
    .st            (st),
    .cfg           (cfg),
    .data_byte     (in_chan.data_byte),
    .start_of_file (in_chan.start_of_file),
    .st_next       (st_next),
    .res           (res),
    .res_count     (res_count)
  );

  assign in_chan.ready = (cnt <= (PW+1)'(1));
  assign push = in_chan.valid && in_chan.ready;
  assign pop = out_chan.valid && out_chan.ready;

  assign out_chan.valid = (cnt != '0);
  assign out_chan.field_code = queue[rptr].code;
  assign out_chan.field_value = queue[rptr].value;
  assign out_chan.final_res = queue[rptr].fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      cfg.layout <= 1'b0;
      cfg.max_len <= xhp_pkg::MAX_HEADER_LENGTH_RESET;
      wptr <= '0;
      rptr <= '0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          xhp_pkg::REG_SEGMENT_LAYOUT: cfg.layout <= cfg_data[0];
          xhp_pkg::REG_MAX_HEADER_LENGTH: cfg.max_len <= cfg_data;
        endcase
      end
      if (push) begin
        st <= st_next;
        wptr <= wptr + PW'(res_count);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      cnt <= cnt + (push ? (PW+1)'(res_count) : '0) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int k = 0; k < xhp_pkg::RES_SLOTS; k++) begin
        if (2'(k) < res_count) begin
          queue[wptr + PW'(k)] <= res[k];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (PW+1)'(xhp_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && !out_chan.ready) |=> (cnt >= $past(cnt)))
    else $error("result dropped while stalled");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (push && !in_chan.start_of_file && (st.phase == xhp_pkg::PH_IDLE))
      |=> (cnt == $past(cnt) - (PW+1)'($past(pop))))
    else $error("result produced while idle");
`endif

endmodule
`default_nettype wire
